>>> sv/sfsg_pkg.sv
`default_nettype none
package sfsg_pkg;

  localparam int CORDIC_STAGES = 16;

  // domain coordinate, vectoring datapath, angle, rotation datapath widths
  localparam int XW = 23;
  localparam int VW = 34;
  localparam int ZW = 20;
  localparam int RW = 20;

  localparam logic [2:0] REG_X_ORIGIN  = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN  = 3'd1;
  localparam logic [2:0] REG_GRID_STEP = 3'd2;
  localparam logic [2:0] REG_SLOPE_OFS = 3'd3;
  localparam logic [2:0] REG_HALF_LEN  = 3'd4;
  localparam logic [2:0] REG_PPU       = 3'd5;
  localparam logic [2:0] REG_CENTER_X  = 3'd6;
  localparam logic [2:0] REG_CENTER_Y  = 3'd7;

  localparam logic signed [RW-1:0] KINV_Q16 = 20'sd39797;
  localparam logic [17:0] PI_Q16 = 18'd205887;

  // 255*t/pi as a multiply by a rounded-up reciprocal, exact for t <= pi
  localparam int RECIP_SHIFT = 48;
  localparam longint unsigned RECIP_PI_L =
    (64'd281474976710656 + 64'd205886) / 64'd205887;
  localparam logic [30:0] RECIP_PI = RECIP_PI_L[30:0];

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } point_t;

  function automatic logic [ZW-1:0] atan_q16(input int idx);
    logic [ZW-1:0] r;
    case (idx)
      0:  r = 20'd51472;
      1:  r = 20'd30385;
      2:  r = 20'd16055;
      3:  r = 20'd8150;
      4:  r = 20'd4091;
      5:  r = 20'd2047;
      6:  r = 20'd1024;
      7:  r = 20'd512;
      8:  r = 20'd256;
      9:  r = 20'd128;
      10: r = 20'd64;
      11: r = 20'd32;
      12: r = 20'd16;
      13: r = 20'd8;
      14: r = 20'd4;
      15: r = 20'd2;
      16: r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/sfsg_cordic_vec.sv
`default_nettype none
module sfsg_cordic_vec (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic signed [sfsg_pkg::VW-1:0]     vy_i,
  input  wire sfsg_pkg::point_t                   pt_i,
  output logic                                    valid_o,
  output logic signed [sfsg_pkg::ZW-1:0]          z_o,
  output sfsg_pkg::point_t                        pt_o
);

  localparam int N = sfsg_pkg::CORDIC_STAGES;
  localparam int VW = sfsg_pkg::VW;
  localparam int ZW = sfsg_pkg::ZW;

  logic                  v_q  [N];
  logic signed [VW-1:0]  vx_q [N];
  logic signed [VW-1:0]  vy_q [N];
  logic signed [ZW-1:0]  z_q  [N];
  sfsg_pkg::point_t      pt_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = signed'(sfsg_pkg::atan_q16(g));
    logic                 v_in;
    logic signed [VW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;
    sfsg_pkg::point_t     p_in;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = VW'(65536);
      assign y_in = vy_i;
      assign z_in = '0;
      assign p_in = pt_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign x_in = vx_q[g-1];
      assign y_in = vy_q[g-1];
      assign z_in = z_q[g-1];
      assign p_in = pt_q[g-1];
    end

    always_comb begin
      if (y_in > 0) begin
        x_d = x_in + (y_in >>> g);
        y_d = y_in - (x_in >>> g);
        z_d = z_in + ATAN;
      end else begin
        x_d = x_in - (y_in >>> g);
        y_d = y_in + (x_in >>> g);
        z_d = z_in - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vx_q[g] <= x_d;
        vy_q[g] <= y_d;
        z_q[g]  <= z_d;
        pt_q[g] <= p_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign z_o     = z_q[N-1];
  assign pt_o    = pt_q[N-1];

endmodule
`default_nettype wire

>>> sv/sfsg_cordic_rot.sv
`default_nettype none
module sfsg_cordic_rot (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic signed [sfsg_pkg::ZW-1:0]     z_i,
  input  wire sfsg_pkg::point_t                   pt_i,
  output logic                                    valid_o,
  output logic signed [sfsg_pkg::RW-1:0]          rx_o,
  output logic signed [sfsg_pkg::RW-1:0]          ry_o,
  output logic signed [sfsg_pkg::ZW-1:0]          z_o,
  output sfsg_pkg::point_t                        pt_o
);

  localparam int N = sfsg_pkg::CORDIC_STAGES;
  localparam int RW = sfsg_pkg::RW;
  localparam int ZW = sfsg_pkg::ZW;

  logic                  v_q  [N];
  logic signed [RW-1:0]  rx_q [N];
  logic signed [RW-1:0]  ry_q [N];
  logic signed [ZW-1:0]  rz_q [N];
  logic signed [ZW-1:0]  z_q  [N];
  sfsg_pkg::point_t      pt_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = signed'(sfsg_pkg::atan_q16(g));
    logic                 v_in;
    logic signed [RW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] r_in, r_d, z_in;
    sfsg_pkg::point_t     p_in;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = sfsg_pkg::KINV_Q16;
      assign y_in = '0;
      assign r_in = z_i;
      assign z_in = z_i;
      assign p_in = pt_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign x_in = rx_q[g-1];
      assign y_in = ry_q[g-1];
      assign r_in = rz_q[g-1];
      assign z_in = z_q[g-1];
      assign p_in = pt_q[g-1];
    end

    always_comb begin
      if (r_in >= 0) begin
        x_d = x_in - (y_in >>> g);
        y_d = y_in + (x_in >>> g);
        r_d = r_in - ATAN;
      end else begin
        x_d = x_in + (y_in >>> g);
        y_d = y_in - (x_in >>> g);
        r_d = r_in + ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[g] <= x_d;
        ry_q[g] <= y_d;
        rz_q[g] <= r_d;
        z_q[g]  <= z_in;
        pt_q[g] <= p_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign rx_o    = rx_q[N-1];
  assign ry_o    = ry_q[N-1];
  assign z_o     = z_q[N-1];
  assign pt_o    = pt_q[N-1];

endmodule
`default_nettype wire

>>> sv/sfsg_pixel_map.sv
`default_nettype none
module sfsg_pixel_map (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic signed [sfsg_pkg::RW-1:0]     rx_i,
  input  wire logic signed [sfsg_pkg::RW-1:0]     ry_i,
  input  wire logic signed [sfsg_pkg::ZW-1:0]     z_i,
  input  wire sfsg_pkg::point_t                   pt_i,
  input  wire logic [14:0]                        half_len_i,
  input  wire logic [9:0]                         ppu_i,
  input  wire logic [11:0]                        center_x_i,
  input  wire logic [11:0]                        center_y_i,
  output logic                                    valid_o,
  output logic signed [15:0]                      start_px_o,
  output logic signed [15:0]                      start_py_o,
  output logic signed [15:0]                      end_px_o,
  output logic signed [15:0]                      end_py_o,
  output logic [7:0]                              fade_level_o
);

  localparam int PW = 34;
  localparam int QW = 30;
  localparam int HW = 46;
  localparam int SW = 52;
  localparam int TW = SW - 24;

  logic [3:0] v_q;

  // stage 1: scale by pixels per unit, fade numerator
  logic signed [PW-1:0] xp_q, yp_q;
  logic signed [QW-1:0] qx_q, qy_q;
  logic [25:0]          n_q;
  logic [17:0]          az_d, t_d;

  always_comb begin
    az_d = (z_i < 0) ? 18'(-z_i) : 18'(z_i);
    if (az_d > sfsg_pkg::PI_Q16) begin
      az_d = sfsg_pkg::PI_Q16;
    end
    t_d = sfsg_pkg::PI_Q16 - az_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp_q <= $signed(PW'(pt_i.x)) * $signed(PW'(ppu_i));
      yp_q <= $signed(PW'(pt_i.y)) * $signed(PW'(ppu_i));
      qx_q <= $signed(QW'(rx_i)) * $signed(QW'(ppu_i));
      qy_q <= $signed(QW'(ry_i)) * $signed(QW'(ppu_i));
      n_q  <= 26'(t_d) * 26'd255;
    end
  end

  // stage 2: half length, reciprocal multiply
  logic signed [PW-1:0] xp2_q, yp2_q;
  logic signed [HW-1:0] hx_q, hy_q;
  logic [56:0]          prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp2_q  <= xp_q;
      yp2_q  <= yp_q;
      hx_q   <= $signed(HW'(qx_q)) * $signed(HW'(half_len_i));
      hy_q   <= $signed(HW'(qy_q)) * $signed(HW'(half_len_i));
      prod_q <= 57'(n_q) * 57'(sfsg_pkg::RECIP_PI);
    end
  end

  // stage 3: q24 pixel sums with rounding
  logic signed [SW-1:0] cx_d, cy_d, xb_d, yb_d, hx_d, hy_d;
  logic signed [SW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [8:0]           fq_d;
  logic [7:0]           fade_q;

  always_comb begin
    cx_d = ($signed(SW'(center_x_i)) <<< 24) + SW'(64'sd8388608);
    cy_d = ($signed(SW'(center_y_i)) <<< 24) + SW'(64'sd8388608);
    xb_d = SW'(xp2_q) <<< 16;
    yb_d = SW'(yp2_q) <<< 16;
    hx_d = SW'(hx_q);
    hy_d = SW'(hy_q);
    fq_d = prod_q[56:sfsg_pkg::RECIP_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q   <= cx_d + xb_d - hx_d;
      sy_q   <= cy_d - yb_d + hy_d;
      ex_q   <= cx_d + xb_d + hx_d;
      ey_q   <= cy_d - yb_d - hy_d;
      fade_q <= (fq_d > 9'd255) ? 8'd255 : fq_d[7:0];
    end
  end

  // stage 4: shift down and saturate
  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    logic signed [TW-1:0] p;
    logic signed [15:0]   r;
    p = TW'(v >>> 24);
    if (p > TW'(32767)) begin
      r = 16'sh7fff;
    end else if (p < -TW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = p[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start_px_o   <= sat16(sx_q);
      start_py_o   <= sat16(sy_q);
      end_px_o     <= sat16(ex_q);
      end_py_o     <= sat16(ey_q);
      fade_level_o <= fade_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign valid_o = v_q[3];

endmodule
`default_nettype wire

>>> sv/slope_field_segment_generator_core.sv
// channel    dir  tdata fields, lowest bit first
// s_axis     in   col_index[5:0], row_index[11:6], zero pad to 16
// m_axis     out  start_px, start_py, end_px, end_py (16 each), fade_level (8)
// cfg        in   cfg_we_i, cfg_addr_i, cfg_wdata_i, one register per write
//
// one request per cycle when the output is empty or taken; the pipeline holds the
// unrolled vectoring and rotation cordic stages
// all stages advance together when the output is empty or taken
// reset clears valid bits; config registers return to their defaults
`default_nettype none
module slope_field_segment_generator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // col_index, row_index
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata    // start_px, start_py, end_px, end_py, fade_level
);

  localparam int XW = sfsg_pkg::XW;
  localparam int VW = sfsg_pkg::VW;

  logic signed [15:0] x_org_q, y_org_q, ofs_q;
  logic [14:0]        step_q, hl_q;
  logic [9:0]         ppu_q;
  logic [11:0]        cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_org_q <= -16'sd1280;
      y_org_q <= -16'sd1280;
      step_q  <= 15'd128;
      ofs_q   <= 16'sd768;
      hl_q    <= 15'd38;
      ppu_q   <= 10'd60;
      cx_q    <= 12'd400;
      cy_q    <= 12'd300;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sfsg_pkg::REG_X_ORIGIN:  x_org_q <= cfg_wdata_i;
        sfsg_pkg::REG_Y_ORIGIN:  y_org_q <= cfg_wdata_i;
        sfsg_pkg::REG_GRID_STEP: step_q  <= cfg_wdata_i[14:0];
        sfsg_pkg::REG_SLOPE_OFS: ofs_q   <= cfg_wdata_i;
        sfsg_pkg::REG_HALF_LEN:  hl_q    <= cfg_wdata_i[14:0];
        sfsg_pkg::REG_PPU:       ppu_q   <= cfg_wdata_i[9:0];
        sfsg_pkg::REG_CENTER_X:  cx_q    <= cfg_wdata_i[11:0];
        sfsg_pkg::REG_CENTER_Y:  cy_q    <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // domain point
  logic             v0_q;
  sfsg_pkg::point_t pt0_q;
  logic [5:0]       col, row;

  assign col = s_axis_tdata[5:0];
  assign row = s_axis_tdata[11:6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt0_q.x <= $signed(XW'(x_org_q)) + $signed(XW'(col) * XW'(step_q));
      pt0_q.y <= $signed(XW'(y_org_q)) + $signed(XW'(row) * XW'(step_q));
    end
  end

  logic signed [VW-1:0] vy0;
  assign vy0 = ($signed(VW'(ofs_q)) - ($signed(VW'(pt0_q.y)) <<< 1)) <<< 8;

  logic                               v1, v2;
  logic signed [sfsg_pkg::ZW-1:0]     z1, z2;
  logic signed [sfsg_pkg::RW-1:0]     rx2, ry2;
  sfsg_pkg::point_t                   pt1, pt2;

  sfsg_cordic_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .vy_i    (vy0),
    .pt_i    (pt0_q),
    .valid_o (v1),
    .z_o     (z1),
    .pt_o    (pt1)
  );

  sfsg_cordic_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .z_i     (z1),
    .pt_i    (pt1),
    .valid_o (v2),
    .rx_o    (rx2),
    .ry_o    (ry2),
    .z_o     (z2),
    .pt_o    (pt2)
  );

  logic signed [15:0] spx, spy, epx, epy;
  logic [7:0]         fade;

  sfsg_pixel_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (v2),
    .rx_i         (rx2),
    .ry_i         (ry2),
    .z_i          (z2),
    .pt_i         (pt2),
    .half_len_i   (hl_q),
    .ppu_i        (ppu_q),
    .center_x_i   (cx_q),
    .center_y_i   (cy_q),
    .valid_o      (m_axis_tvalid),
    .start_px_o   (spx),
    .start_py_o   (spy),
    .end_px_o     (epx),
    .end_py_o     (epy),
    .fade_level_o (fade)
  );

  assign m_axis_tdata = {fade, epy, epx, spy, spx};

endmodule
`default_nettype wire

>>> bench/slope_field_segment_checker.sv
`default_nettype none
module slope_field_segment_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [71:0] m_axis_tdata,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [7:0]         fade;
    logic signed [15:0] end_py;
    logic signed [15:0] end_px;
    logic signed [15:0] start_py;
    logic signed [15:0] start_px;
  } segment_t;

  logic [15:0] shadow_q [8];
  segment_t segments_q [$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] pixel_sat(longint v);
    longint p;
    p = floor_shr(v + (64'sd1 <<< 23), 24);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl [17];
    tbl = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tbl[i] : 0;
  endfunction

  function automatic segment_t predict_segment(logic [5:0] col, logic [5:0] row);
    longint x, y, s, vx, vy, z, nx, ny, rx, ry, rz, az, fade;
    longint hl, ppu, cx, cy, step;
    segment_t r;
    hl   = shadow_q[sfsg_pkg::REG_HALF_LEN][14:0];
    ppu  = shadow_q[sfsg_pkg::REG_PPU][9:0];
    cx   = shadow_q[sfsg_pkg::REG_CENTER_X][11:0];
    cy   = shadow_q[sfsg_pkg::REG_CENTER_Y][11:0];
    step = shadow_q[sfsg_pkg::REG_GRID_STEP][14:0];
    x = longint'($signed(shadow_q[sfsg_pkg::REG_X_ORIGIN])) + col * step;
    y = longint'($signed(shadow_q[sfsg_pkg::REG_Y_ORIGIN])) + row * step;
    s = longint'($signed(shadow_q[sfsg_pkg::REG_SLOPE_OFS])) - 2 * y;
    vx = 65536; vy = s * 256; z = 0;
    for (int i = 0; i < sfsg_pkg::CORDIC_STAGES; i++) begin
      if (vy > 0) begin
        nx = vx + floor_shr(vy, i); ny = vy - floor_shr(vx, i); z += atan_entry(i);
      end else begin
        nx = vx - floor_shr(vy, i); ny = vy + floor_shr(vx, i); z -= atan_entry(i);
      end
      vx = nx; vy = ny;
    end
    rx = 39797; ry = 0; rz = z;
    for (int i = 0; i < sfsg_pkg::CORDIC_STAGES; i++) begin
      if (rz >= 0) begin
        nx = rx - floor_shr(ry, i); ny = ry + floor_shr(rx, i); rz -= atan_entry(i);
      end else begin
        nx = rx + floor_shr(ry, i); ny = ry - floor_shr(rx, i); rz += atan_entry(i);
      end
      rx = nx; ry = ny;
    end
    r.start_px = pixel_sat(cx * 16777216 + (x * 65536 - rx * hl) * ppu);
    r.start_py = pixel_sat(cy * 16777216 - (y * 65536 - ry * hl) * ppu);
    r.end_px   = pixel_sat(cx * 16777216 + (x * 65536 + rx * hl) * ppu);
    r.end_py   = pixel_sat(cy * 16777216 - (y * 65536 + ry * hl) * ppu);
    az = (z < 0) ? -z : z;
    if (az > 205887) az = 205887;
    fade = (255 * (205887 - az)) / 205887;
    if (fade > 255) fade = 255;
    if (fade < 0) fade = 0;
    r.fade = fade[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = segments_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t got, want;
    if (!rst_ni) begin
      shadow_q[0] <= 16'hFB00; shadow_q[1] <= 16'hFB00; shadow_q[2] <= 16'd128;
      shadow_q[3] <= 16'd768;  shadow_q[4] <= 16'd38;   shadow_q[5] <= 16'd60;
      shadow_q[6] <= 16'd400;  shadow_q[7] <= 16'd300;
      segments_q.delete();
    end else begin
      if (cfg_we_i) shadow_q[cfg_addr_i] <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        segments_q.insert(segments_q.size(),
                          predict_segment(s_axis_tdata[5:0], s_axis_tdata[11:6]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (segments_q.size() == 0) begin
          report_mismatch("segment count", 1, 0);
        end else begin
          want = segments_q.pop_front();
          if (got.start_px !== want.start_px)
            report_mismatch("start_px", got.start_px, want.start_px);
          if (got.start_py !== want.start_py)
            report_mismatch("start_py", got.start_py, want.start_py);
          if (got.end_px !== want.end_px)
            report_mismatch("end_px", got.end_px, want.end_px);
          if (got.end_py !== want.end_py)
            report_mismatch("end_py", got.end_py, want.end_py);
          if (got.fade !== want.fade)
            report_mismatch("fade_level", got.fade, want.fade);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> bench/slope_field_segment_generator_core_tb.sv
`default_nettype none
module slope_field_segment_generator_core_tb;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_addr_i = sfsg_pkg::REG_X_ORIGIN;
  logic [15:0] cfg_wdata_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  int          errors, pending;
  bit          sink_quiet = 0;

  slope_field_segment_generator_core uut (.*);

  slope_field_segment_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, with quiet stretches
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_addr_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(logic [5:0] col, logic [5:0] row, bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_config;
    write_reg(sfsg_pkg::REG_X_ORIGIN, 16'($urandom_range(0, 65535)));
    write_reg(sfsg_pkg::REG_Y_ORIGIN, 16'($urandom_range(0, 65535)));
    write_reg(sfsg_pkg::REG_GRID_STEP,
              16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                              : $urandom_range(1, 600)));
    write_reg(sfsg_pkg::REG_SLOPE_OFS, 16'($urandom_range(0, 65535)));
    write_reg(sfsg_pkg::REG_HALF_LEN,
              16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                              : $urandom_range(0, 512)));
    write_reg(sfsg_pkg::REG_PPU, 16'($urandom_range(0, 1023)));
    write_reg(sfsg_pkg::REG_CENTER_X, 16'($urandom_range(0, 4095)));
    write_reg(sfsg_pkg::REG_CENTER_Y, 16'($urandom_range(0, 4095)));
  endtask

  initial begin
    bit busy;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: corners, centre and the zero-slope row (y = 1.5)
    send_point(0, 0, 0);   send_point(63, 63, 0); send_point(0, 63, 0);
    send_point(63, 0, 0);  send_point(21, 13, 0); send_point(42, 13, 1);
    send_point(10, 10, 1); send_point(6'h2a, 6'h15, 0); send_point(6'h15, 6'h2a, 0);
    drain();

    // extremes of every register
    write_reg(sfsg_pkg::REG_X_ORIGIN, 16'h7FFF);  write_reg(sfsg_pkg::REG_Y_ORIGIN, 16'h8000);
    write_reg(sfsg_pkg::REG_GRID_STEP, 16'h7FFF); write_reg(sfsg_pkg::REG_SLOPE_OFS, 16'h8000);
    write_reg(sfsg_pkg::REG_HALF_LEN, 16'h7FFF);  write_reg(sfsg_pkg::REG_PPU, 16'h03FF);
    write_reg(sfsg_pkg::REG_CENTER_X, 16'h0FFF);  write_reg(sfsg_pkg::REG_CENTER_Y, 16'h0FFF);
    send_point(0, 0, 0); send_point(63, 63, 0); send_point(63, 0, 1); send_point(0, 63, 0);
    drain();

    write_reg(sfsg_pkg::REG_X_ORIGIN, 16'h8000);  write_reg(sfsg_pkg::REG_Y_ORIGIN, 16'h7FFF);
    write_reg(sfsg_pkg::REG_GRID_STEP, 16'd0);    write_reg(sfsg_pkg::REG_SLOPE_OFS, 16'h7FFF);
    write_reg(sfsg_pkg::REG_HALF_LEN, 16'd0);     write_reg(sfsg_pkg::REG_PPU, 16'd0);
    write_reg(sfsg_pkg::REG_CENTER_X, 16'd0);     write_reg(sfsg_pkg::REG_CENTER_Y, 16'd0);
    send_point(0, 0, 0); send_point(63, 63, 1); send_point(5, 40, 0);
    drain();

    // slope exactly zero everywhere
    write_reg(sfsg_pkg::REG_Y_ORIGIN, 16'd0); write_reg(sfsg_pkg::REG_SLOPE_OFS, 16'd0);
    write_reg(sfsg_pkg::REG_PPU, 16'd1);      write_reg(sfsg_pkg::REG_HALF_LEN, 16'd256);
    send_point(7, 0, 0); send_point(63, 0, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      sink_quiet = (ph % 4 == 3);
      busy = (ph % 3 == 2);
      for (int n = 0; n < 80; n++)
        send_point(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), busy);
      drain();
    end
    sink_quiet = 0;

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
